// ----- design/cpio_newc_stream_parser_top_assert.svh -----
// Assertion macros for the checker file of the cpio stream parser.
`ifndef CPIO_NEWC_STREAM_PARSER_TOP_ASSERT_SVH
`define CPIO_NEWC_STREAM_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CPIO_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("cpio parser check failed");

// Next-cycle implication, disabled during reset.
`define CPIO_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("cpio parser check failed");

`endif

// ----- design/cpio_pkg.sv -----
package cpio_pkg;

  // Header layout
  localparam int unsigned HdrLen     = 110;
  localparam int unsigned MagicLen   = 6;
  localparam int unsigned EndNameLen = 11;

  // Header field numbers that are kept
  localparam logic [3:0] FIELD_MODE     = 4'd1;
  localparam logic [3:0] FIELD_SIZE     = 4'd6;
  localparam logic [3:0] FIELD_MAJOR    = 4'd9;
  localparam logic [3:0] FIELD_MINOR    = 4'd10;
  localparam logic [3:0] FIELD_NAMESIZE = 4'd11;

  typedef enum logic [5:0] {
    PH_HEADER   = 6'b000001,
    PH_NAME     = 6'b000010,
    PH_NAME_PAD = 6'b000100,
    PH_DATA     = 6'b001000,
    PH_DATA_PAD = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  // Hex digit value; anything outside 0-9 and A-F counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

  // Name of the end record, NUL included
  function automatic logic [7:0] end_name_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h54; // T
      4'd1:    ch = 8'h52; // R
      4'd2:    ch = 8'h41; // A
      4'd3:    ch = 8'h49; // I
      4'd4:    ch = 8'h4C; // L
      4'd5:    ch = 8'h45; // E
      4'd6:    ch = 8'h52; // R
      4'd7:    ch = 8'h21; // !
      4'd8:    ch = 8'h21;
      4'd9:    ch = 8'h21;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- design/cpio_newc_stream_parser_top.sv -----
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// input    | in        | in_valid/in_stall  | data_byte
// result   | out       | out_valid/out_stall| kind, byte_value, last, file_mode, file_size,
//          |           |                    | name_length, rdev_major_num, rdev_minor_num
//
// One archive byte is taken per clock while in_stall is low; its result, if any, shows in the next cycle.
// All decoding sits between the state registers and the result register.
// Synchronous reset returns to the header phase; there is no clearing pass.
// in_stall is high only while a result is held and out_stall is high.
// Header, padding and post-end-record bytes are consumed without a result.
module cpio_newc_stream_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  byte_value,
  output logic        last,
  output logic [31:0] file_mode,
  output logic [31:0] file_size,
  output logic [31:0] name_length,
  output logic [31:0] rdev_major_num,
  output logic [31:0] rdev_minor_num
);

  // Parser state
  cpio_pkg::phase_t phase, phase_next;
  logic [6:0]  header_position, header_position_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] hex_accumulator, hex_accumulator_next;
  logic        field_stopped, field_stopped_next;
  logic [1:0]  pad_remaining, pad_remaining_next;
  logic [31:0] mode_store, mode_store_next;
  logic [31:0] size_store, size_store_next;
  logic [31:0] namesize_store, namesize_store_next;
  logic [31:0] major_store, major_store_next;
  logic [31:0] minor_store, minor_store_next;
  logic        trailer_match, trailer_match_next;
  logic [3:0]  name_pos, name_pos_next;

  // Per-byte decode
  logic        accept;
  logic [6:0]  hdr_rel;
  logic [2:0]  char_off;
  logic [3:0]  field_num;
  logic [31:0] acc_base;
  logic        stop_base;
  logic [1:0]  name_pad_len;
  logic [1:0]  data_pad_len;
  logic        go_name, go_name_pad, go_data, go_data_pad, go_header;
  logic        res_valid;
  cpio_pkg::kind_t res_kind;
  logic        res_last;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign hdr_rel      = header_position - 7'(cpio_pkg::MagicLen);
  assign char_off     = hdr_rel[2:0];
  assign field_num    = hdr_rel[6:3];
  assign acc_base     = (char_off == 3'd0) ? 32'd0 : hex_accumulator;
  assign stop_base    = (char_off == 3'd0) ? 1'b0 : field_stopped;
  assign name_pad_len = 2'(2'd2 - namesize_store[1:0]);
  assign data_pad_len = 2'(2'd0 - size_store[1:0]);

  // Next state and result for the byte on the input
  always_comb begin
    phase_next           = phase;
    header_position_next = header_position;
    bytes_remaining_next = bytes_remaining;
    hex_accumulator_next = hex_accumulator;
    field_stopped_next   = field_stopped;
    pad_remaining_next   = pad_remaining;
    mode_store_next      = mode_store;
    size_store_next      = size_store;
    namesize_store_next  = namesize_store;
    major_store_next     = major_store;
    minor_store_next     = minor_store;
    trailer_match_next   = trailer_match;
    name_pos_next        = name_pos;
    go_name              = 1'b0;
    go_name_pad          = 1'b0;
    go_data              = 1'b0;
    go_data_pad          = 1'b0;
    go_header            = 1'b0;
    res_valid            = 1'b0;
    res_kind             = cpio_pkg::KIND_NAME;
    res_last             = 1'b0;

    case (phase)
      cpio_pkg::PH_HEADER: begin
        // hex fields follow the magic
        if (header_position >= 7'(cpio_pkg::MagicLen)) begin
          hex_accumulator_next = acc_base;
          field_stopped_next   = stop_base;
          if (!stop_base) begin
            if (data_byte == 8'h00) field_stopped_next = 1'b1;
            else hex_accumulator_next = {acc_base[27:0], 4'b0000} +
                                        32'(cpio_pkg::hex_value(data_byte));
          end
          if (char_off == 3'd7) begin
            case (field_num)
              cpio_pkg::FIELD_MODE:     mode_store_next     = hex_accumulator_next;
              cpio_pkg::FIELD_SIZE:     size_store_next     = hex_accumulator_next;
              cpio_pkg::FIELD_MAJOR:    major_store_next    = hex_accumulator_next;
              cpio_pkg::FIELD_MINOR:    minor_store_next    = hex_accumulator_next;
              cpio_pkg::FIELD_NAMESIZE: namesize_store_next = hex_accumulator_next;
              default: ;
            endcase
          end
        end
        if (header_position == 7'(cpio_pkg::HdrLen - 1)) go_name = 1'b1;
        else header_position_next = header_position + 7'd1;
      end
      cpio_pkg::PH_NAME: begin
        // compare against the end record while the name streams out
        if (name_pos < 4'(cpio_pkg::EndNameLen)) begin
          if (data_byte != cpio_pkg::end_name_char(name_pos)) trailer_match_next = 1'b0;
          name_pos_next = name_pos + 4'd1;
        end
        bytes_remaining_next = bytes_remaining - 32'd1;
        res_valid = 1'b1;
        if (bytes_remaining == 32'd1) begin
          res_last = 1'b1;
          if (trailer_match_next && namesize_store >= 32'(cpio_pkg::EndNameLen)) begin
            res_kind   = cpio_pkg::KIND_END;
            phase_next = cpio_pkg::PH_DONE;
          end else begin
            go_name_pad = 1'b1;
          end
        end
      end
      cpio_pkg::PH_NAME_PAD: begin
        pad_remaining_next = pad_remaining - 2'd1;
        if (pad_remaining == 2'd1) go_data = 1'b1;
      end
      cpio_pkg::PH_DATA: begin
        bytes_remaining_next = bytes_remaining - 32'd1;
        res_valid = 1'b1;
        res_kind  = cpio_pkg::KIND_DATA;
        if (bytes_remaining == 32'd1) begin
          res_last    = 1'b1;
          go_data_pad = 1'b1;
        end
      end
      cpio_pkg::PH_DATA_PAD: begin
        pad_remaining_next = pad_remaining - 2'd1;
        if (pad_remaining == 2'd1) go_header = 1'b1;
      end
      default: ;
    endcase

    // Phase entries; empty sections fall through to the next one
    if (go_name) begin
      trailer_match_next   = 1'b1;
      name_pos_next        = 4'd0;
      bytes_remaining_next = namesize_store_next;
      if (namesize_store_next == 32'd0) go_name_pad = 1'b1;
      else phase_next = cpio_pkg::PH_NAME;
    end
    if (go_name_pad) begin
      if (name_pad_len == 2'd0) go_data = 1'b1;
      else begin
        pad_remaining_next = name_pad_len;
        phase_next         = cpio_pkg::PH_NAME_PAD;
      end
    end
    if (go_data) begin
      bytes_remaining_next = size_store;
      if (size_store == 32'd0) go_data_pad = 1'b1;
      else phase_next = cpio_pkg::PH_DATA;
    end
    if (go_data_pad) begin
      pad_remaining_next = data_pad_len;
      if (data_pad_len == 2'd0) go_header = 1'b1;
      else phase_next = cpio_pkg::PH_DATA_PAD;
    end
    if (go_header) begin
      phase_next           = cpio_pkg::PH_HEADER;
      header_position_next = 7'd0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= cpio_pkg::PH_HEADER;
      header_position <= 7'd0;
      bytes_remaining <= 32'd0;
      hex_accumulator <= 32'd0;
      field_stopped   <= 1'b0;
      pad_remaining   <= 2'd0;
      mode_store      <= 32'd0;
      size_store      <= 32'd0;
      namesize_store  <= 32'd0;
      major_store     <= 32'd0;
      minor_store     <= 32'd0;
      trailer_match   <= 1'b1;
      name_pos        <= 4'd0;
    end else if (accept) begin
      phase           <= phase_next;
      header_position <= header_position_next;
      bytes_remaining <= bytes_remaining_next;
      hex_accumulator <= hex_accumulator_next;
      field_stopped   <= field_stopped_next;
      pad_remaining   <= pad_remaining_next;
      mode_store      <= mode_store_next;
      size_store      <= size_store_next;
      namesize_store  <= namesize_store_next;
      major_store     <= major_store_next;
      minor_store     <= minor_store_next;
      trailer_match   <= trailer_match_next;
      name_pos        <= name_pos_next;
    end
  end

  // Result register: loads on a producing transfer, clears when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      kind           <= res_kind;
      byte_value     <= data_byte;
      last           <= res_last;
      file_mode      <= mode_store;
      file_size      <= size_store;
      name_length    <= namesize_store;
      rdev_major_num <= major_store;
      rdev_minor_num <= minor_store;
    end
  end

endmodule

// ----- design/cpio_chk.sv -----
`include "cpio_newc_stream_parser_top_assert.svh"

module cpio_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  data_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [7:0]  byte_value,
  input logic        last,
  input logic [31:0] file_mode,
  input logic [31:0] file_size,
  input logic [31:0] name_length,
  input logic [31:0] rdev_major_num,
  input logic [31:0] rdev_minor_num
);

  logic end_xfer;
  logic kind_ok;

  assign end_xfer = out_valid && !out_stall && kind == cpio_pkg::KIND_END;
  assign kind_ok  = kind == cpio_pkg::KIND_NAME || kind == cpio_pkg::KIND_DATA ||
                    kind == cpio_pkg::KIND_END;

  // Only the three defined result kinds appear
  `CPIO_ASSERT_NOW(a_kind_legal, clk, rst, out_valid, kind_ok)

  // End of archive is always the last name byte of the end record
  `CPIO_ASSERT_NOW(a_end_is_last, clk, rst, out_valid && kind == cpio_pkg::KIND_END, last)

  // Nothing follows the end record
  `CPIO_ASSERT_NEXT(a_quiet_after_end, clk, rst, end_xfer, !out_valid)

  // A held result keeps its byte
  `CPIO_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(byte_value))

endmodule

bind cpio_newc_stream_parser_top cpio_chk u_cpio_chk (.*);
